@@ design/softf_pkg.sv @@
package softf_pkg;
    localparam int VisibleLines = 240;
    localparam int LineCycles   = 341;
    localparam int TimeW        = 17;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // sprite covers line when 0 <= line - y < height
    function automatic logic covers(input logic [7:0] line, input logic [7:0] y,
                                    input logic tall);
        logic [8:0] d;
        begin
            d = {1'b0, line} - {1'b0, y};
            covers = !d[8] && (tall ? (d[7:4] == 4'd0) : (d[7:3] == 5'd0));
        end
    endfunction
endpackage

@@ design/softf_oam.sv @@
module softf_oam
    import softf_pkg::*;
(
    input  logic       clk,
    input  logic       we,
    input  logic [7:0] waddr,
    input  logic [7:0] wdata,
    input  logic [7:0] raddr,
    output logic [7:0] rdata
);
    logic [7:0] mem [256];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ design/softf_seq.sv @@
module softf_seq
    import softf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  logic [7:0]       start_line,
    input  logic             tall,
    input  logic [7:0]       rdata,
    output logic [7:0]       raddr,
    output logic             busy,
    output logic             done,
    output logic             found,
    output logic [TimeW-1:0] flag_time
);
    typedef enum logic [2:0] {S_IDLE, S_COUNT, S_EVAL, S_NINTH, S_MUL} state_t;

    state_t            state_reg;
    logic [7:0]        line_reg;
    logic [8:0]        i_reg;      // byte index into sprite memory, can reach 0x100
    logic [1:0]        m_reg;
    logic [3:0]        remain_reg; // count of in-range sprites still needed
    logic              pend_reg;   // a read is in flight for the current i
    logic              done_reg;
    logic              found_reg;
    logic [TimeW-1:0]  time_reg;
    logic              tall_reg;
    logic [7:0]        raddr_next;

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign found     = found_reg;
    assign flag_time = time_reg;
    assign raddr     = raddr_next;

    // the count pass is folded into evaluation: a line with under 8 sprites
    // never reaches the ninth search
    always_comb
    begin
        case (state_reg)
            S_NINTH: raddr_next = i_reg[7:0] + {6'd0, m_reg};
            default: raddr_next = i_reg[7:0];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            found_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (go)
                    begin
                        tall_reg   <= tall;
                        line_reg   <= start_line;
                        i_reg      <= 9'd0;
                        remain_reg <= 4'd8;
                        pend_reg   <= 1'b0;
                        if ({24'd0, start_line} >= VisibleLines)
                        begin
                            found_reg <= 1'b0;
                            time_reg  <= '0;
                            done_reg  <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= S_EVAL;
                        end
                    end
                end
                S_EVAL:
                begin
                    if (!pend_reg)
                    begin
                        pend_reg <= 1'b1;
                    end
                    else
                    begin
                        pend_reg <= 1'b0;
                        if (covers(line_reg, rdata, tall_reg) && remain_reg == 4'd1)
                        begin
                            i_reg     <= i_reg + 9'd4;
                            m_reg     <= 2'd0;
                            state_reg <= S_NINTH;
                            if (i_reg + 9'd4 >= 9'h100)
                            begin
                                state_reg <= S_COUNT;
                            end
                        end
                        else
                        begin
                            if (covers(line_reg, rdata, tall_reg))
                            begin
                                remain_reg <= remain_reg - 4'd1;
                            end
                            i_reg <= i_reg + 9'd4;
                            if (i_reg + 9'd4 >= 9'h100)
                            begin
                                state_reg <= S_COUNT;
                            end
                        end
                    end
                end
                S_NINTH:
                begin
                    if (!pend_reg)
                    begin
                        pend_reg <= 1'b1;
                    end
                    else
                    begin
                        pend_reg <= 1'b0;
                        i_reg    <= i_reg + 9'd4;
                        m_reg    <= m_reg + 2'd1;
                        if (covers(line_reg, rdata, tall_reg))
                        begin
                            state_reg <= S_MUL;
                        end
                        else if (i_reg + 9'd4 >= 9'h100)
                        begin
                            state_reg <= S_COUNT;
                        end
                    end
                end
                S_MUL:
                begin
                    found_reg <= 1'b1;
                    time_reg  <= TimeW'({9'd0, line_reg} * 17'(LineCycles)
                                        + {9'd0, i_reg[8:1]});
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_COUNT:
                begin
                    // next line or finish not found
                    i_reg      <= 9'd0;
                    remain_reg <= 4'd8;
                    if ({24'd0, line_reg} + 32'd1 >= VisibleLines)
                    begin
                        found_reg <= 1'b0;
                        time_reg  <= '0;
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        line_reg  <= line_reg + 8'd1;
                        state_reg <= S_EVAL;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

@@ design/sprite_overflow_time_finder_top.sv @@
// a write transfer writes sprite memory directly; a search walks scanlines with up to 64
// sprite reads and a line step each, plus a multiply state on a hit; done is registered
// throughput: writes back to back when not busy, searches one at a time, one oam read port
// reset: rst_n async active low clears control and tall_reg; sprite memory
// is filled with 0xff by a sweep over all 256 addresses during which busy is high
// results are flagged by done, high for one cycle; the receiver cannot stall
module sprite_overflow_time_finder_top
    import softf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             opcode,
    input  logic [7:0]       oam_addr,
    input  logic [7:0]       oam_data,
    input  logic [7:0]       start_scanline,
    input  logic             cfg_we,
    input  logic             cfg_wdata,
    output logic             done,
    output logic             overflow_found,
    output logic [TimeW-1:0] overflow_time
);
    logic       tall_reg;
    logic       clr_reg;     // clearing sweep active
    logic [7:0] clr_cnt_reg;
    logic       seq_busy;
    logic       go;
    logic       mem_we;
    logic [7:0] mem_waddr;
    logic [7:0] mem_wdata;
    logic [7:0] rd_addr;
    logic [7:0] rd_data;

    assign busy = clr_reg | seq_busy;
    assign go   = start && !busy && opcode == OP_SEARCH;

    // memory write port: clearing sweep or write transfer
    assign mem_we    = clr_reg || (start && !busy && opcode == OP_WRITE);
    assign mem_waddr = clr_reg ? clr_cnt_reg : oam_addr;
    assign mem_wdata = clr_reg ? 8'hFF : oam_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tall_reg    <= 1'b0;
            clr_reg     <= 1'b1;
            clr_cnt_reg <= 8'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                tall_reg <= cfg_wdata;
            end
            if (clr_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 8'd1;
                if (clr_cnt_reg == 8'hFF)
                begin
                    clr_reg <= 1'b0;
                end
            end
        end
    end

    softf_oam u_oam (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    softf_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (go),
        .start_line (start_scanline),
        .tall       (tall_reg),
        .rdata      (rd_data),
        .raddr      (rd_addr),
        .busy       (seq_busy),
        .done       (done),
        .found      (overflow_found),
        .flag_time  (overflow_time)
    );
endmodule
